// ----- rtl/core/calibrated_tick_timer_defines.svh -----
// Assertion macros shared by the calibrated tick timer RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef CALIBRATED_TICK_TIMER_DEFINES_SVH
`define CALIBRATED_TICK_TIMER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define CTT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CTT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ctt_pkg.sv -----
// Package for the calibrated tick timer: types, register indexes and constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctt_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_DELAY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_HZ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_MHZ   = 3'd4;

    // Identification leaves that enable each frequency source
    localparam logic [7:0] LEAF_RATIO = 8'h15;
    localparam logic [7:0] LEAF_BASE  = 8'h16;

    localparam logic [31:0] CRYSTAL_DEFAULT_HZ = 32'd38400000;
    localparam logic [63:0] FREQ_MIN_HZ        = 64'd100000000;
    localparam logic [63:0] FREQ_MAX_HZ        = 64'd10000000000;
    localparam logic [33:0] FREQ_FALLBACK_HZ   = 34'd800000000;
    localparam logic [33:0] HZ_PER_MHZ         = 34'd1000000;
    localparam logic [33:0] MS_PER_S           = 34'd1000;

    // Derived values that match the fallback frequency
    localparam logic [23:0] FALLBACK_TICKS_PER_MS  = 24'd800000;
    localparam logic [13:0] FALLBACK_MHZ_QUOT      = 14'd800;

    // Shared divider geometry
    localparam int unsigned DIV_W     = 64;
    localparam int unsigned DIVISOR_W = 34;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

    typedef struct packed {
        logic [7:0]  leaf_limit;
        logic [31:0] ratio_den;
        logic [31:0] ratio_num;
        logic [31:0] osc_hz;
        logic [15:0] core_mhz;
    } ctt_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RMUL,
        S_RSRC,
        S_RDIVF,
        S_RCLAMP,
        S_RDIVK,
        S_RDIVQ,
        S_RDIVMS,
        S_DMUL,
        S_DSTART,
        S_DDIV,
        S_DFIN
    } ctt_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/ctt_div.sv -----
// Shared restoring divider: 64-bit dividend, 34-bit divisor, one quotient bit per cycle.
// Depends on ctt_pkg for its widths.
`default_nettype none

module ctt_div
    import ctt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [DIV_W-1:0]          quotient,
    output logic [DIVISOR_W-1:0]      remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]      dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // The partial remainder stays below the divisor, so one shifted step fits in 35 bits.
    assign shifted = {rem_reg, dq_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_STEPS;
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            dq_next  = {dq_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ctt_core.sv -----
// Sequencer, counter state and result register of the calibrated tick timer.
// Depends on ctt_pkg, ctt_div and the assertion macros in calibrated_tick_timer_defines.svh.
`default_nettype none
`include "calibrated_tick_timer_defines.svh"

module ctt_core
    import ctt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctt_cfg_t    cfg,
    input  wire logic        cfg_dirty,
    output logic             refresh_ack,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] delay_us,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [63:0]      tick_count,
    output logic [63:0]      ms_count,
    output logic             delay_busy,
    output logic [33:0]      tsc_freq_hz
);

    ctt_state_t state_reg, state_next;

    logic [63:0] counter_reg, counter_next;
    logic [63:0] ms_reg, ms_next;
    logic [23:0] rem_reg, rem_next;
    logic [63:0] start_reg, start_next;
    logic [45:0] ticks_reg, ticks_next;
    logic        armed_reg, armed_next;

    logic [33:0] freq_reg, freq_next;
    logic [23:0] divk_reg, divk_next;
    logic [13:0] q_reg, q_next;
    logic [19:0] r_reg, r_next;

    logic [63:0] prod_reg, prod_next;
    logic [35:0] basef_reg, basef_next;
    logic [63:0] cand_reg, cand_next;
    logic [31:0] us_reg, us_next;
    logic [45:0] usq_reg, usq_next;
    logic [51:0] usr_reg, usr_next;

    logic        res_valid_reg, res_valid_next;
    logic [63:0] res_tick_reg, res_tick_next;
    logic [63:0] res_ms_reg, res_ms_next;
    logic        res_busy_reg, res_busy_next;
    logic [33:0] res_freq_reg, res_freq_next;

    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quot;
    logic [DIVISOR_W-1:0]  div_rem;

    logic [31:0] xtal;
    logic        use_ratio;
    logic        use_base;
    logic [33:0] cand_clamped;
    logic        out_free;
    logic        item_acc;
    logic        is_tick;
    logic [63:0] cnt_inc;
    logic        cnt_wrap;
    logic [23:0] rem_inc;
    logic        rem_hit;
    logic [63:0] item_cnt;
    logic [63:0] item_ms;
    logic [23:0] item_rem;
    logic [63:0] item_elapsed;
    logic        item_busy;
    logic        dly_busy;

    ctt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Frequency source selection
    assign xtal      = (cfg.osc_hz != '0) ? cfg.osc_hz : CRYSTAL_DEFAULT_HZ;
    assign use_ratio = (cfg.leaf_limit >= LEAF_RATIO) && (cfg.ratio_num != '0)
                       && (cfg.ratio_den != '0);
    assign use_base  = (cfg.leaf_limit >= LEAF_BASE) && (cfg.core_mhz != '0);
    assign cand_clamped = ((cand_reg < FREQ_MIN_HZ) || (cand_reg > FREQ_MAX_HZ))
                          ? FREQ_FALLBACK_HZ : cand_reg[33:0];

    assign out_free   = !res_valid_reg || !result_stall;
    assign item_stall = !((state_reg == S_IDLE) && !cfg_dirty && out_free);
    assign item_acc   = item_valid && !item_stall;

    // The millisecond count follows the counter one tick at a time; the divider
    // only rebuilds it when the frequency is recomputed.
    assign is_tick  = (cmd == CMD_TICK);
    assign cnt_inc  = counter_reg + 64'd1;
    assign cnt_wrap = &counter_reg;
    assign rem_inc  = rem_reg + 24'd1;
    assign rem_hit  = (rem_inc == divk_reg);
    assign item_cnt = is_tick ? cnt_inc : counter_reg;
    assign item_ms  = !is_tick ? ms_reg : (cnt_wrap ? 64'd0 :
                      (rem_hit ? ms_reg + 64'd1 : ms_reg));
    assign item_rem = !is_tick ? rem_reg : ((cnt_wrap || rem_hit) ? 24'd0 : rem_inc);
    assign item_elapsed = item_cnt - start_reg;
    assign item_busy    = armed_reg && (item_elapsed < {18'd0, ticks_reg});
    assign dly_busy     = (ticks_reg != '0);

    always_comb
    begin
        state_next   = state_reg;
        counter_next = counter_reg;
        ms_next      = ms_reg;
        rem_next     = rem_reg;
        start_next   = start_reg;
        ticks_next   = ticks_reg;
        armed_next   = armed_reg;
        freq_next    = freq_reg;
        divk_next    = divk_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        prod_next    = prod_reg;
        basef_next   = basef_reg;
        cand_next    = cand_reg;
        us_next      = us_reg;
        usq_next     = usq_reg;
        usr_next     = usr_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_tick_next  = res_tick_reg;
        res_ms_next    = res_ms_reg;
        res_busy_next  = res_busy_reg;
        res_freq_next  = res_freq_reg;
        refresh_ack  = 1'b0;
        div_start    = 1'b0;
        div_dividend = counter_reg;
        div_divisor  = {10'd0, divk_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_dirty)
                begin
                    refresh_ack = 1'b1;
                    state_next  = S_RMUL;
                end
                else if (item_acc)
                begin
                    case (cmd)
                        CMD_DELAY:
                        begin
                            us_next    = delay_us;
                            state_next = S_DMUL;
                        end
                        CMD_TICK, CMD_READ:
                        begin
                            counter_next   = item_cnt;
                            ms_next        = item_ms;
                            rem_next       = item_rem;
                            armed_next     = item_busy;
                            res_valid_next = 1'b1;
                            res_tick_next  = item_cnt;
                            res_ms_next    = item_ms;
                            res_busy_next  = item_busy;
                            res_freq_next  = freq_reg;
                        end
                        default:
                        begin
                            // The unused code behaves as a read.
                            armed_next     = item_busy;
                            res_valid_next = 1'b1;
                            res_tick_next  = counter_reg;
                            res_ms_next    = ms_reg;
                            res_busy_next  = item_busy;
                            res_freq_next  = freq_reg;
                        end
                    endcase
                end
            end
            S_RMUL:
            begin
                prod_next  = {32'd0, xtal} * {32'd0, cfg.ratio_num};
                basef_next = {20'd0, cfg.core_mhz} * {2'd0, HZ_PER_MHZ};
                state_next = S_RSRC;
            end
            S_RSRC:
            begin
                if (use_ratio)
                begin
                    div_start    = 1'b1;
                    div_dividend = prod_reg;
                    div_divisor  = {2'd0, cfg.ratio_den};
                    state_next   = S_RDIVF;
                end
                else
                begin
                    cand_next  = use_base ? {28'd0, basef_reg} : {30'd0, FREQ_FALLBACK_HZ};
                    state_next = S_RCLAMP;
                end
            end
            S_RDIVF:
            begin
                if (div_done)
                begin
                    cand_next  = div_quot;
                    state_next = S_RCLAMP;
                end
            end
            S_RCLAMP:
            begin
                freq_next    = cand_clamped;
                div_start    = 1'b1;
                div_dividend = {30'd0, cand_clamped};
                div_divisor  = MS_PER_S;
                state_next   = S_RDIVK;
            end
            S_RDIVK:
            begin
                if (div_done)
                begin
                    divk_next    = div_quot[23:0];
                    div_start    = 1'b1;
                    div_dividend = {30'd0, freq_reg};
                    div_divisor  = HZ_PER_MHZ;
                    state_next   = S_RDIVQ;
                end
            end
            S_RDIVQ:
            begin
                if (div_done)
                begin
                    q_next       = div_quot[13:0];
                    r_next       = div_rem[19:0];
                    div_start    = 1'b1;
                    div_dividend = counter_reg;
                    div_divisor  = {10'd0, divk_reg};
                    state_next   = S_RDIVMS;
                end
            end
            S_RDIVMS:
            begin
                if (div_done)
                begin
                    ms_next    = div_quot;
                    rem_next   = div_rem[23:0];
                    state_next = S_IDLE;
                end
            end
            S_DMUL:
            begin
                // Split the frequency as whole megahertz plus a remainder so
                // that nothing overflows.
                usq_next   = {14'd0, us_reg} * {32'd0, q_reg};
                usr_next   = {20'd0, us_reg} * {32'd0, r_reg};
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_start    = 1'b1;
                div_dividend = {12'd0, usr_reg};
                div_divisor  = HZ_PER_MHZ;
                state_next   = S_DDIV;
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    ticks_next = usq_reg + div_quot[45:0];
                    start_next = counter_reg;
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                if (out_free)
                begin
                    armed_next     = dly_busy;
                    res_valid_next = 1'b1;
                    res_tick_next  = counter_reg;
                    res_ms_next    = ms_reg;
                    res_busy_next  = dly_busy;
                    res_freq_next  = freq_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            counter_reg   <= '0;
            ms_reg        <= '0;
            rem_reg       <= '0;
            start_reg     <= '0;
            ticks_reg     <= '0;
            armed_reg     <= 1'b0;
            freq_reg      <= FREQ_FALLBACK_HZ;
            divk_reg      <= FALLBACK_TICKS_PER_MS;
            q_reg         <= FALLBACK_MHZ_QUOT;
            r_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            ms_reg        <= ms_next;
            rem_reg       <= rem_next;
            start_reg     <= start_next;
            ticks_reg     <= ticks_next;
            armed_reg     <= armed_next;
            freq_reg      <= freq_next;
            divk_reg      <= divk_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        basef_reg    <= basef_next;
        cand_reg     <= cand_next;
        us_reg       <= us_next;
        usq_reg      <= usq_next;
        usr_reg      <= usr_next;
        res_tick_reg <= res_tick_next;
        res_ms_reg   <= res_ms_next;
        res_busy_reg <= res_busy_next;
        res_freq_reg <= res_freq_next;
    end

    assign result_valid = res_valid_reg;
    assign tick_count   = res_tick_reg;
    assign ms_count     = res_ms_reg;
    assign delay_busy   = res_busy_reg;
    assign tsc_freq_hz  = res_freq_reg;

    `CTT_ASSERT_IMPLIES(a_div_start_idle, div_start, !div_busy,
        "divider started while still busy")
    `CTT_ASSERT_ALWAYS(a_freq_in_range,
        ({30'd0, freq_reg} >= FREQ_MIN_HZ) && ({30'd0, freq_reg} <= FREQ_MAX_HZ),
        "derived frequency outside the clamp range")
    `CTT_ASSERT_ALWAYS(a_divk_nonzero, divk_reg != '0,
        "ticks per millisecond is zero")
    `CTT_ASSERT_IMPLIES(a_rem_bound, state_reg == S_IDLE, rem_reg < divk_reg,
        "millisecond remainder not below ticks per millisecond")
    `CTT_ASSERT_IMPLIES(a_busy_armed, res_valid_reg && res_busy_reg, armed_reg,
        "busy result shown without an armed delay")

endmodule

`default_nettype wire

// ----- rtl/core/calibrated_tick_timer.sv -----
// Calibrated tick timer: 64-bit tick counter with derived frequency and one-shot delay.
//
// Usage:
//   Configuration registers (leaf_limit, ratio_den, ratio_num, osc_hz, core_mhz, at
//   indexes 0 to 4) are written over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
//   always high. Each write to one of these registers marks the derived frequency stale. Write only while idle.
//   Items (cmd, delay_us) transfer when item_valid is high and item_stall low; every item
//   gives exactly one result (tick_count, ms_count, delay_busy, tsc_freq_hz) that transfers
//   when result_valid is high and result_stall low.
//   Tick and read items are registered into the result on the next edge, and a new
//   item can be taken every cycle while the result register drains.
//   A delay start makes one 64-step pass of the shared divider that scales the
//   microsecond length by the fractional megahertz.
//   After reset and after any write to one of these registers the sequencer recomputes the
//   frequency, the ticks per millisecond and the millisecond count with three passes of the
//   shared divider, or four when the ratio source adds one; meanwhile item_stall is high.
//   Reset clears the counter, the delay state and all configuration registers, and leaves the frequency
//   recomputation pending. While result_stall is high the result holds and at most the
//   already accepted item completes; no further item is taken until the register is free.
// Depends on ctt_pkg and ctt_core.
`default_nettype none

module calibrated_tick_timer
    import ctt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [1:0]           cmd,
    input  wire logic [31:0]          delay_us,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [63:0]               tick_count,
    output logic [63:0]               ms_count,
    output logic                      delay_busy,
    output logic [33:0]               tsc_freq_hz
);

    ctt_cfg_t cfg_reg, cfg_next;
    logic     dirty_reg, dirty_next;
    logic     refresh_ack;
    logic     cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next   = cfg_reg;
        dirty_next = dirty_reg && !refresh_ack;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_LEAF_LIMIT:
                begin
                    cfg_next.leaf_limit = cfg_data[7:0];
                    dirty_next          = 1'b1;
                end
                CFG_RATIO_DEN:
                begin
                    cfg_next.ratio_den = cfg_data;
                    dirty_next         = 1'b1;
                end
                CFG_RATIO_NUM:
                begin
                    cfg_next.ratio_num = cfg_data;
                    dirty_next         = 1'b1;
                end
                CFG_OSC_HZ:
                begin
                    cfg_next.osc_hz = cfg_data;
                    dirty_next      = 1'b1;
                end
                CFG_CORE_MHZ:
                begin
                    cfg_next.core_mhz = cfg_data[15:0];
                    dirty_next        = 1'b1;
                end
                default:
                begin
                    // Writes beyond the register list are dropped.
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            dirty_reg <= 1'b1;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            dirty_reg <= dirty_next;
        end
    end

    ctt_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cfg_dirty    (dirty_reg),
        .refresh_ack  (refresh_ack),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .delay_us     (delay_us),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .tick_count   (tick_count),
        .ms_count     (ms_count),
        .delay_busy   (delay_busy),
        .tsc_freq_hz  (tsc_freq_hz)
    );

endmodule

`default_nettype wire

// ----- test/tick_timer_checker.sv -----
// Checker for the calibrated tick timer: follows register writes, predicts every reading
// and compares it with the transferred result. Depends on ctt_pkg.
`timescale 1ns / 1ps

module tick_timer_checker
    import ctt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 item_valid,
    input  wire logic                 item_stall,
    input  wire logic [1:0]           cmd,
    input  wire logic [31:0]          delay_us,
    input  wire logic                 result_valid,
    input  wire logic                 result_stall,
    input  wire logic [63:0]          tick_count,
    input  wire logic [63:0]          ms_count,
    input  wire logic                 delay_busy,
    input  wire logic [33:0]          tsc_freq_hz,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [63:0] ticks;
        logic [63:0] millis;
        logic        busy;
        logic [33:0] rate;
    } timer_reading_t;

    ctt_cfg_t       regs = '0;
    logic [63:0]    count = '0;
    logic [63:0]    span_origin = '0;
    logic [45:0]    span_len = '0;
    logic           span_armed = 1'b0;
    timer_reading_t due_readings[$];
    int             mismatches = 0;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    // Tick rate after source selection and the sanity clamp.
    function automatic logic [63:0] derived_rate(input ctt_cfg_t c);
        logic [63:0] xtal;
        logic [63:0] f;
        f = 64'(FREQ_FALLBACK_HZ);
        if (c.leaf_limit >= LEAF_RATIO && c.ratio_num != 0 && c.ratio_den != 0)
        begin
            xtal = (c.osc_hz != 0) ? 64'(c.osc_hz) : 64'(CRYSTAL_DEFAULT_HZ);
            f = (xtal * 64'(c.ratio_num)) / 64'(c.ratio_den);
        end
        else if (c.leaf_limit >= LEAF_BASE && c.core_mhz != 0)
        begin
            f = 64'(c.core_mhz) * 64'(HZ_PER_MHZ);
        end
        if (f < FREQ_MIN_HZ || f > FREQ_MAX_HZ)
            f = 64'(FREQ_FALLBACK_HZ);
        return f;
    endfunction

    // The product is taken at 96 bits, so the floor is exact before truncation.
    function automatic logic [45:0] delay_span(input logic [31:0] us, input logic [63:0] rate);
        logic [95:0] scaled;
        scaled = 96'(us) * 96'(rate);
        return 46'(scaled / 96'(HZ_PER_MHZ));
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        timer_reading_t want;
        logic [63:0]    rate;
        logic           busy;
        if (!rst_n)
        begin
            regs = '0;
            count = '0;
            span_origin = '0;
            span_len = '0;
            span_armed = 1'b0;
            due_readings.delete();
            pending <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LEAF_LIMIT: regs.leaf_limit = cfg_data[7:0];
                    CFG_RATIO_DEN:  regs.ratio_den = cfg_data;
                    CFG_RATIO_NUM:  regs.ratio_num = cfg_data;
                    CFG_OSC_HZ:     regs.osc_hz = cfg_data;
                    CFG_CORE_MHZ:   regs.core_mhz = cfg_data[15:0];
                    default: ;
                endcase
            end

            // Results come from a register, so they never belong to an item taken this edge.
            if (result_valid && !result_stall)
            begin
                if (due_readings.size() == 0)
                begin
                    $error("result transfer with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_readings.pop_front();
                    compare_field("tick_count", want.ticks, tick_count);
                    compare_field("ms_count", want.millis, ms_count);
                    compare_field("delay_busy", 64'(want.busy), 64'(delay_busy));
                    compare_field("tsc_freq_hz", 64'(want.rate), 64'(tsc_freq_hz));
                end
            end

            if (item_valid && !item_stall)
            begin
                rate = derived_rate(regs);
                case (cmd)
                    CMD_TICK:  count = count + 64'd1;
                    CMD_DELAY:
                    begin
                        span_origin = count;
                        span_len = delay_span(delay_us, rate);
                        span_armed = 1'b1;
                    end
                    default: ;
                endcase
                busy = 1'b0;
                if (span_armed)
                begin
                    if (count - span_origin < 64'(span_len))
                        busy = 1'b1;
                    else
                        span_armed = 1'b0;
                end
                due_readings.push_back('{count, count / (rate / 64'(MS_PER_S)), busy,
                                         rate[33:0]});
            end

            fail_count <= mismatches;
            pending <= due_readings.size();
        end
    end

endmodule

// ----- test/calibrated_tick_timer_tb.sv -----
// Top of the calibrated tick timer testbench: clock, reset, register settings and item
// traffic with random idling, plus the verdict. Depends on ctt_pkg and tick_timer_checker.
`timescale 1ns / 1ps

module calibrated_tick_timer_tb
    import ctt_pkg::*;
();

    localparam logic [1:0] CMD_SPARE    = 2'd3;
    localparam int         SETTINGS_N   = 14;
    localparam int         PHASE_ITEMS  = 45;
    localparam int         LONG_RUN     = 40;
    localparam int         HOLD_OFF     = 400;
    localparam int         DRAIN_CYCLES = 300;
    localparam int         QUIET_LIMIT  = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic [1:0]           cmd = CMD_TICK;
    logic [31:0]          delay_us = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [63:0]          tick_count;
    logic [63:0]          ms_count;
    logic                 delay_busy;
    logic [33:0]          tsc_freq_hz;
    int                   fail_count;
    int                   pending;

    logic                 idle_on = 1'b1;
    logic                 stall_on = 1'b1;
    int                   hold_seq = 0;
    ctt_cfg_t             settings[SETTINGS_N];

    calibrated_tick_timer uut (.*);

    tick_timer_checker u_checker (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Leaves valid high on return so that back-to-back transfers need no second assignment.
    task automatic send_item(input logic [1:0] c, input logic [31:0] u);
        while (idle_on && $urandom_range(99) < 27)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        cmd <= c;
        delay_us <= u;
        do @(posedge clk); while (item_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Bits above each register's width carry random values; one spare index is hit too.
    task automatic load_settings(input ctt_cfg_t s, input int spare);
        write_reg(CFG_LEAF_LIMIT, ($urandom() & 32'hFFFF_FF00) | 32'(s.leaf_limit));
        write_reg(CFG_RATIO_DEN, s.ratio_den);
        write_reg(CFG_RATIO_NUM, s.ratio_num);
        write_reg(CFG_OSC_HZ, s.osc_hz);
        write_reg(CFG_CORE_MHZ, ($urandom() & 32'hFFFF_0000) | 32'(s.core_mhz));
        write_reg(CFG_IDX_W'(CFG_CORE_MHZ + 1 + (spare % 3)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_idle();
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Mostly delay starts followed by tick runs, so that delays both elapse and get replaced.
    task automatic run_traffic(input int quota);
        int          sent;
        int          run;
        int          pick;
        logic [31:0] us;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(99) < 65)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    us = $urandom_range(3);
                else if (pick < 80)
                    us = $urandom_range(1000);
                else
                    us = $urandom();
                send_item(CMD_DELAY, us);
                sent++;
                run = $urandom_range(150);
                repeat (run)
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        send_item(CMD_READ, $urandom());
                    else if (pick < 10)
                        send_item(CMD_SPARE, $urandom());
                    else
                        send_item(CMD_TICK, $urandom());
                    sent++;
                end
            end
            else
            begin
                send_item(2'($urandom_range(3)), $urandom());
                sent++;
            end
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= stall_on && ($urandom_range(99) < 27);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        bit quiet_phase;
        settings[0]  = '{8'h15, 32'd1, 32'd3, 32'd0, 16'd0};
        settings[1]  = '{8'h15, 32'd1, 32'd4, 32'd25000000, 16'd0};
        settings[2]  = '{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF};
        settings[3]  = '{8'h15, 32'hFFFF_FFFF, 32'd1, 32'd0, 16'd100};
        settings[4]  = '{8'h20, 32'd1, 32'd3, 32'hFFFF_FFFF, 16'd0};
        settings[5]  = '{8'h16, 32'd1, 32'd5, 32'd2000000000, 16'd0};
        settings[6]  = '{8'h16, 32'd0, 32'd7, 32'd0, 16'hFFFF};
        settings[7]  = '{8'h16, 32'd3, 32'd0, 32'd0, 16'd100};
        settings[8]  = '{8'h16, 32'd0, 32'd0, 32'd0, 16'd10000};
        settings[9]  = '{8'h15, 32'd0, 32'd0, 32'd0, 16'd2500};
        settings[10] = '{8'h14, 32'd7, 32'd9, 32'd12345678, 16'd999};
        settings[11] = '{8'h16, 32'd0, 32'd0, 32'd0, 16'd0};
        settings[12] = '{8'h16, 32'd0, 32'd0, 32'd0, 16'd99};
        settings[13] = '{8'h15, 32'd3, 32'd10, 32'd33333333, 16'd0};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: fallback rate, spare command, zero-length and replaced delays.
        send_item(CMD_READ, 32'hFFFF_FFFF);
        send_item(CMD_SPARE, 32'h0000_0000);
        send_item(CMD_TICK, 32'h5555_5555);
        send_item(CMD_TICK, 32'hAAAA_AAAA);
        send_item(CMD_DELAY, 32'd0);
        send_item(CMD_READ, 32'd0);
        send_item(CMD_DELAY, 32'd1);
        send_item(CMD_TICK, 32'd0);
        send_item(CMD_READ, 32'd0);
        send_item(CMD_DELAY, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 32'd0);
        send_item(CMD_DELAY, 32'd0);
        send_item(CMD_READ, 32'd0);

        for (int p = 0; p < SETTINGS_N; p++)
        begin
            settle_idle();
            load_settings(settings[p], p);
            quiet_phase = (p == 1 || p == 5);
            idle_on <= !quiet_phase;
            stall_on <= !quiet_phase;
            if (p == 0)
                hold_seq <= hold_seq + 1;
            if (p == 1)
            begin
                // At 100 MHz one microsecond is exactly 100 ticks, so the first delay runs
                // out on the hundredth tick; the 1000 us delay stays pending over the short run.
                send_item(CMD_DELAY, 32'd1);
                repeat (101) send_item(CMD_TICK, $urandom());
                send_item(CMD_DELAY, 32'd1000);
                for (int i = 0; i < LONG_RUN; i++)
                    send_item((i % 10 == 9) ? CMD_READ : CMD_TICK, $urandom());
            end
            run_traffic(PHASE_ITEMS);
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
